// ----- src/whpd_pkg.sv -----
// Package with shared types and constants for the heap dispatcher.
`default_nettype none
package whpd_pkg;
    localparam int HeapDepthDefault = 64;
    localparam int PriW = 16;
    localparam int ElW = 25;
    localparam int ReqW = 24;
    localparam int KeyW = 41;
    localparam int StatW = 3;
    localparam int SwW = 32;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_REQUEUED = 3'd2,
        ST_RETIRED  = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOP_RD,
        S_TOP_WT,
        S_DN_RD,
        S_DN_WT,
        S_DN_CMP,
        S_PUSH,
        S_UP_RD,
        S_UP_WT,
        S_UP_CMP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic       load;
        logic       top_read;
        logic       move_last;
        logic       dn_read;
        logic       dn_step;
        logic       push;
        logic       up_read;
        logic       up_step;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic       is_insert;
        logic       full;
        logic       empty;
        logic       dn_more;
        logic       dn_swap;
        logic       requeue;
        logic       up_more;
        logic       up_swap;
    } stat_t;
endpackage
`default_nettype wire

// ----- src/whpd_if.sv -----
// Valid-ready channel interface carrying one payload word.
`default_nettype none
interface whpd_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/whpd_ctrl.sv -----
// Controller state machine that sequences insert and dispatch operations.
`default_nettype none
module whpd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire whpd_pkg::stat_t  stat,
    output whpd_pkg::cmd_t        cmd
);
    whpd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= whpd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            whpd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = whpd_pkg::S_TOP_RD;
                end
            end
            whpd_pkg::S_TOP_RD:
            begin
                if (stat.is_insert)
                begin
                    state_next = stat.full ? whpd_pkg::S_OUT : whpd_pkg::S_PUSH;
                end
                else if (stat.empty)
                begin
                    state_next = whpd_pkg::S_OUT;
                end
                else
                begin
                    state_next = whpd_pkg::S_TOP_WT;
                end
            end
            whpd_pkg::S_TOP_WT: state_next = whpd_pkg::S_DN_RD;
            whpd_pkg::S_DN_RD:
            begin
                if (stat.dn_more)
                begin
                    state_next = whpd_pkg::S_DN_WT;
                end
                else
                begin
                    state_next = stat.requeue ? whpd_pkg::S_PUSH : whpd_pkg::S_OUT;
                end
            end
            whpd_pkg::S_DN_WT: state_next = whpd_pkg::S_DN_CMP;
            whpd_pkg::S_DN_CMP:
            begin
                if (stat.dn_swap)
                begin
                    state_next = whpd_pkg::S_DN_RD;
                end
                else
                begin
                    state_next = stat.requeue ? whpd_pkg::S_PUSH : whpd_pkg::S_OUT;
                end
            end
            whpd_pkg::S_PUSH: state_next = whpd_pkg::S_UP_RD;
            whpd_pkg::S_UP_RD:
            begin
                state_next = stat.up_more ? whpd_pkg::S_UP_WT : whpd_pkg::S_OUT;
            end
            whpd_pkg::S_UP_WT: state_next = whpd_pkg::S_UP_CMP;
            whpd_pkg::S_UP_CMP:
            begin
                state_next = stat.up_swap ? whpd_pkg::S_UP_RD : whpd_pkg::S_OUT;
            end
            whpd_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = whpd_pkg::S_IDLE;
                end
            end
            default: state_next = whpd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            whpd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            whpd_pkg::S_TOP_RD: cmd.top_read = 1'b1;
            whpd_pkg::S_TOP_WT: cmd.move_last = 1'b1;
            whpd_pkg::S_DN_RD: cmd.dn_read = 1'b1;
            whpd_pkg::S_DN_CMP: cmd.dn_step = 1'b1;
            whpd_pkg::S_PUSH: cmd.push = 1'b1;
            whpd_pkg::S_UP_RD: cmd.up_read = 1'b1;
            whpd_pkg::S_UP_CMP: cmd.up_step = 1'b1;
            whpd_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                cmd.finish = out_ready;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ----- src/whpd_dp.sv -----
// Datapath with the heap memory, key multipliers and result registers.
`default_nettype none
module whpd_dp #(
    parameter int HEAP_DEPTH = whpd_pkg::HeapDepthDefault
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire whpd_pkg::cmd_t               cmd,
    output whpd_pkg::stat_t                   stat,
    input  wire logic                         in_mode,
    input  wire logic [whpd_pkg::PriW-1:0]    in_pri,
    input  wire logic [whpd_pkg::ReqW-1:0]    in_req,
    output whpd_pkg::status_t                 res_status,
    output logic [whpd_pkg::PriW-1:0]         res_pri,
    output logic [whpd_pkg::ElW-1:0]          res_el,
    output logic [whpd_pkg::ReqW-1:0]         res_req,
    output logic [whpd_pkg::SwW-1:0]          res_sw,
    output logic [$clog2(HEAP_DEPTH+1)-1:0]   res_occ
);
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int EW = whpd_pkg::PriW + whpd_pkg::ElW + whpd_pkg::ReqW;
    localparam int PW = whpd_pkg::PriW;
    localparam int LW = whpd_pkg::ElW;
    localparam int RW = whpd_pkg::ReqW;

    logic [EW-1:0] mem [HEAP_DEPTH];

    logic [CW-1:0] count_reg;
    logic [whpd_pkg::SwW-1:0] sw_reg;
    logic mode_reg;
    whpd_pkg::status_t status_reg;
    logic [PW-1:0] pri_reg;
    logic [LW-1:0] el_reg;
    logic [RW-1:0] req_reg;
    logic [AW-1:0] idx_reg;
    logic [EW-1:0] cur_reg;
    logic [EW-1:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0] ra_reg, rb_reg;
    logic two_reg;
    logic we;
    logic [AW-1:0] wa;
    logic [EW-1:0] wd;
    logic we2;
    logic [AW-1:0] wa2;
    logic [EW-1:0] wd2;

    function automatic logic [whpd_pkg::KeyW-1:0] key_of(input logic [EW-1:0] e);
        logic [LW:0] el_inc;
        logic [PW+LW:0] prod;
        el_inc = {1'b0, e[RW +: LW]} + (LW+1)'(1);
        prod = e[EW-1 -: PW] * el_inc;
        return whpd_pkg::KeyW'(prod);
    endfunction

    logic [whpd_pkg::KeyW-1:0] ka, kb;
    logic [whpd_pkg::KeyW-1:0] kc_reg;

    assign ka = key_of(rd_a_reg);
    assign kb = key_of(rd_b_reg);

    logic [CW:0] left_w;
    logic [AW-1:0] left_a, right_a, par_a;
    logic [AW:0] par_w;
    always_comb
    begin
        left_w = {idx_reg, 1'b0} + (CW+1)'(1);
        left_a = AW'(left_w);
        right_a = AW'(left_w + (CW+1)'(1));
        par_w = ({1'b0, idx_reg} - (AW+1)'(1)) >> 1;
        par_a = AW'(par_w);
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[ra_reg];
        rd_b_reg <= mem[rb_reg];
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (we2)
        begin
            mem[wa2] <= wd2;
        end
    end

    logic dn_pick_right;
    always_comb
    begin
        dn_pick_right = two_reg && (kb < ka);
        stat.is_insert = !mode_reg;
        stat.full = count_reg >= CW'(HEAP_DEPTH);
        stat.empty = count_reg == '0;
        stat.dn_more = left_w < {1'b0, count_reg};
        stat.dn_swap = (dn_pick_right ? kb : ka) < kc_reg;
        stat.requeue = el_reg < req_reg;
        stat.up_more = idx_reg != '0;
        stat.up_swap = ka > kc_reg;
        we = 1'b0;
        wa = idx_reg;
        wd = cur_reg;
        we2 = 1'b0;
        wa2 = idx_reg;
        wd2 = rd_a_reg;
        if (cmd.move_last)
        begin
            we = 1'b1;
            wa = '0;
            wd = rd_b_reg;
        end
        if (cmd.dn_step && stat.dn_swap)
        begin
            we = 1'b1;
            wa = idx_reg;
            wd = dn_pick_right ? rd_b_reg : rd_a_reg;
            we2 = 1'b1;
            wa2 = dn_pick_right ? rb_reg : ra_reg;
            wd2 = cur_reg;
        end
        if (cmd.push)
        begin
            we = 1'b1;
            wa = AW'(count_reg);
            wd = cur_reg;
        end
        if (cmd.up_step && stat.up_swap)
        begin
            we = 1'b1;
            wa = idx_reg;
            wd = rd_a_reg;
            we2 = 1'b1;
            wa2 = ra_reg;
            wd2 = cur_reg;
        end
    end

    logic [CW-1:0] last_c;
    assign last_c = count_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sw_reg <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                mode_reg <= in_mode;
            end
            if (cmd.top_read && !stat.is_insert && !stat.empty)
            begin
                count_reg <= last_c;
            end
            if (cmd.push)
            begin
                count_reg <= count_reg + CW'(1);
                if (!stat.is_insert)
                begin
                    sw_reg <= sw_reg + whpd_pkg::SwW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kc_reg <= key_of(cur_reg);
        if (cmd.load)
        begin
            pri_reg <= in_mode ? '0 : in_pri;
            req_reg <= in_mode ? '0 : in_req;
            el_reg <= '0;
            cur_reg <= {in_pri, LW'(0), in_req};
            status_reg <= in_mode ? whpd_pkg::ST_EMPTY : whpd_pkg::ST_INSERTED;
            ra_reg <= '0;
            rb_reg <= AW'(last_c);
        end
        if (cmd.top_read)
        begin
            idx_reg <= '0;
            if (stat.is_insert)
            begin
                status_reg <= stat.full ? whpd_pkg::ST_FULL : whpd_pkg::ST_INSERTED;
                idx_reg <= AW'(count_reg);
            end
        end
        if (cmd.move_last)
        begin
            pri_reg <= rd_a_reg[EW-1 -: PW];
            el_reg <= rd_a_reg[RW +: LW];
            req_reg <= rd_a_reg[RW-1:0];
            cur_reg <= rd_b_reg;
            status_reg <= (rd_a_reg[RW +: LW] < rd_a_reg[RW-1:0])
                ? whpd_pkg::ST_REQUEUED : whpd_pkg::ST_RETIRED;
        end
        if (cmd.dn_read)
        begin
            ra_reg <= left_a;
            rb_reg <= right_a;
            two_reg <= ({1'b0, left_w} + (CW+2)'(1)) < {2'b0, count_reg};
            if (!stat.dn_more && stat.requeue)
            begin
                cur_reg <= {pri_reg, el_reg + LW'(pri_reg), req_reg};
                idx_reg <= AW'(count_reg);
            end
        end
        if (cmd.dn_step)
        begin
            if (stat.dn_swap)
            begin
                idx_reg <= dn_pick_right ? rb_reg : ra_reg;
            end
            else if (stat.requeue)
            begin
                cur_reg <= {pri_reg, el_reg + LW'(pri_reg), req_reg};
                idx_reg <= AW'(count_reg);
            end
        end
        if (cmd.up_read)
        begin
            ra_reg <= par_a;
        end
        if (cmd.up_step && stat.up_swap)
        begin
            idx_reg <= ra_reg;
        end
    end

    assign res_status = status_reg;
    assign res_pri = pri_reg;
    assign res_el = el_reg;
    assign res_req = req_reg;
    assign res_sw = sw_reg;
    assign res_occ = count_reg;
endmodule
`default_nettype wire

// ----- src/weighted_heap_process_dispatcher_unit.sv -----
// Top level of the weighted heap process dispatcher.
// An insert reads the top, pushes its entry and sifts it up before its result is offered;
// a dispatch reads the top, moves the last entry to the root and sifts it down, and on a
// requeue pushes the popped entry and sifts it up. A full insert or empty dispatch skips to
// its result. One word is in flight at a time; the next is accepted once the result is taken.
// Reset clears occupancy and the switch counter; heap entries need no clearing.
`default_nettype none
module weighted_heap_process_dispatcher_unit #(
    parameter int HEAP_DEPTH = whpd_pkg::HeapDepthDefault
) (
    input wire logic clk,
    input wire logic rst_n,
    whpd_if.sink     in_ch,
    whpd_if.source   out_ch
);
    whpd_pkg::cmd_t  cmd;
    whpd_pkg::stat_t stat;
    whpd_pkg::status_t st;
    logic [whpd_pkg::PriW-1:0] rp;
    logic [whpd_pkg::ElW-1:0] re;
    logic [whpd_pkg::ReqW-1:0] rr;
    logic [whpd_pkg::SwW-1:0] rs;
    logic [$clog2(HEAP_DEPTH+1)-1:0] ro;

    whpd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    whpd_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_mode(in_ch.data.mode), .in_pri(in_ch.data.priority_req),
        .in_req(in_ch.data.required_time),
        .res_status(st), .res_pri(rp), .res_el(re), .res_req(rr),
        .res_sw(rs), .res_occ(ro)
    );

    always_comb
    begin
        out_ch.data.status = st;
        out_ch.data.sel_priority = rp;
        out_ch.data.sel_elapsed = re;
        out_ch.data.sel_required = rr;
        out_ch.data.switch_total = rs;
        out_ch.data.occupancy = 7'(ro);
    end

    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        ro <= ($clog2(HEAP_DEPTH+1))'(HEAP_DEPTH)) else $error("occupancy overflow");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
    a_sw: assert property (@(posedge clk) disable iff (!rst_n)
        rs != $past(rs) |-> $past(cmd.push)) else $error("switch count moved");
endmodule
`default_nettype wire
